// ----- design/modinv_pkg.sv -----
// modinv_pkg: status codes and fixed port widths for the modular inverse block.
// Depends on nothing; imported by modular_inverse.
`default_nettype none

package modinv_pkg;

  // Widths of the item fields on the ports
  localparam int unsigned VALUE_WIDTH  = 32;
  localparam int unsigned STATUS_WIDTH = 2;

  typedef logic [STATUS_WIDTH-1:0] status_t;

  // Result status codes
  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_NOINV  = 2'd1;
  localparam status_t ST_BADMOD = 2'd2;

endpackage

`default_nettype wire

// ----- design/modular_inverse.sv -----
// modular_inverse: inverse of a value modulo a modulus by the extended Euclidean
// algorithm, one restoring-division bit per cycle. Depends on modinv_pkg.
//
//   channel  ports                               handshake
//   input    in_value, in_modulus                taken when start && !busy
//   result   out_inverse, out_status             valid for one cycle on out_valid
//
// Each Euclid step runs a zero check, the restoring division in the shared step
// unit and then a coefficient update; the zero check that finds a zero remainder
// leads to a final state that registers the result.
// A modulus below two gives its result in the cycle after accept.
// rst_n is synchronous, active low; busy is low after reset.
// The receiver cannot stall: out_valid is a one-cycle strobe.
`default_nettype none

module modular_inverse
  import modinv_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [VALUE_WIDTH-1:0] in_value,
  input  wire logic [VALUE_WIDTH-1:0] in_modulus,
  output logic                        out_valid,
  output logic [VALUE_WIDTH-1:0]      out_inverse,
  output status_t                     out_status
);

  localparam int unsigned W     = OPERAND_WIDTH;
  localparam int unsigned CNT_W = $clog2(W);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_UPD,
    S_FIN
  } state_t;

  state_t           state_r;
  logic [W-1:0]     mod_r;
  logic [W-1:0]     rem_old_r;
  logic [W-1:0]     rem_new_r;
  logic [W:0]       co_old_r;     // two's complement, W+1 bits
  logic [W:0]       co_new_r;
  logic [W-1:0]     part_r;       // partial remainder of the divider
  logic [W-1:0]     quo_r;        // dividend shifting out, quotient shifting in
  logic [W:0]       prod_r;       // running quotient * co_new, Horner form
  logic [CNT_W-1:0] cnt_r;
  logic             out_valid_r;
  logic [VALUE_WIDTH-1:0] out_inverse_r;
  status_t          out_status_r;

  // Operands at the low OPERAND_WIDTH bits
  logic [W-1:0] val_w;
  logic [W-1:0] mod_w;
  assign val_w = W'(in_value);
  assign mod_w = W'(in_modulus);

  // Shared step unit: one restoring division bit and one Horner accumulate
  logic [W:0]   step_trial;
  logic [W:0]   step_diff;
  logic         step_bit;
  logic [W-1:0] step_part;
  logic [W:0]   step_prod;

  always_comb begin
    step_trial = {part_r, quo_r[W-1]};
    step_diff  = step_trial - {1'b0, rem_new_r};
    step_bit   = (step_trial >= {1'b0, rem_new_r});
    step_part  = step_bit ? step_diff[W-1:0] : step_trial[W-1:0];
    step_prod  = {prod_r[W-1:0], 1'b0} + (step_bit ? co_new_r : '0);
  end

  // Final reduction of a negative coefficient
  logic [W:0] fin_coef;
  assign fin_coef = co_old_r[W] ? (co_old_r + {1'b0, mod_r}) : co_old_r;

  // Sequencer with registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            mod_r <= mod_w;
            if (mod_w < W'(2)) begin
              out_valid_r   <= 1'b1;
              out_inverse_r <= '0;
              out_status_r  <= ST_BADMOD;
            end else begin
              rem_old_r <= mod_w;
              rem_new_r <= val_w;
              co_old_r  <= '0;
              co_new_r  <= (W+1)'(1);
              state_r   <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (rem_new_r == '0) begin
            state_r <= S_FIN;
          end else begin
            part_r  <= '0;
            quo_r   <= rem_old_r;
            prod_r  <= '0;
            cnt_r   <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          part_r <= step_part;
          quo_r  <= {quo_r[W-2:0], step_bit};
          prod_r <= step_prod;
          cnt_r  <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(W-1)) begin
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          // shift the remainder and coefficient pairs
          rem_old_r <= rem_new_r;
          rem_new_r <= part_r;
          co_old_r  <= co_new_r;
          co_new_r  <= co_old_r - prod_r;
          state_r   <= S_CHECK;
        end
        S_FIN: begin
          out_valid_r <= 1'b1;
          if (rem_old_r != W'(1)) begin
            out_inverse_r <= '0;
            out_status_r  <= ST_NOINV;
          end else begin
            out_inverse_r <= VALUE_WIDTH'(fin_coef[W-1:0]);
            out_status_r  <= ST_OK;
          end
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy        = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_inverse = out_inverse_r;
  assign out_status  = out_status_r;

  // A result only follows an item that was in progress or just taken
  a_strobe_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy) || $past(start))
    else $error("result strobe without an item in progress");

  // Bad modulus answers in the next cycle
  a_badmod_next: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && mod_w < W'(2)) |=> out_valid && out_status == ST_BADMOD)
    else $error("bad modulus not reported in the next cycle");

  // Failed searches report a zero inverse
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> out_inverse == '0)
    else $error("nonzero inverse with failing status");

  // A found inverse is reduced below the modulus
  a_inv_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_OK) |-> out_inverse < VALUE_WIDTH'(mod_r))
    else $error("inverse not below the modulus");

endmodule

`default_nettype wire
